### design/nvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvs_pkg
// Shared types and constants for the nearest value search block.
// ----------------------------------------------------------------------------
package nvs_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 8;
	localparam int BEST_W = 30;
	localparam int DIFF_W = DATA_W + 1;

	// running best at the start of every scan
	localparam logic [BEST_W-1:0] START_BEST = BEST_W'(1000000000);

	// request function codes
	localparam logic FUNC_QUERY = 1'b0;
	localparam logic FUNC_LOAD  = 1'b1;

	typedef struct packed {
		logic                     func;
		logic signed [DATA_W-1:0] value;
		logic                     load_last;
	} req_t;

	typedef struct packed {
		logic [POS_W-1:0]         closest_position;
		logic signed [DATA_W-1:0] closest_value;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

endpackage

### design/nvs_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvs_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface nvs_stream_if #(
	parameter type payload_t = logic
);

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);

endinterface

### design/nearest_value_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_value_search
// Table of signed values with a linear nearest-value query over one memory.
// ----------------------------------------------------------------------------
// load transaction: the next request is taken in the following cycle
// query transaction: N = max(list length, 1) table entries are read, one memory read per cycle,
//   into a two-stage compare pipeline; the result then waits for a free output register
// next request taken in the cycle after the result is loaded into the output register
// reset clears list length, load position and the entry zero flag; table contents
//   other than entry zero are undefined until loaded
module nearest_value_search
	import nvs_pkg::*;
#(
	parameter int LIST_DEPTH = 256
) (
	input logic         clk,
	input logic         arst_n,
	nvs_stream_if.sink   req,
	nvs_stream_if.source rsp
);

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int LW = AW + 1;
	localparam logic [LW-1:0] DEPTH_L = LW'(LIST_DEPTH);

	// table memory
	logic signed [DATA_W-1:0] value_mem [LIST_DEPTH];

	state_t                   state_q;
	logic [LW-1:0]            list_len_q;
	logic [LW-1:0]            load_pos_q;
	logic                     e0_written_q;
	logic [LW-1:0]            scan_cnt_q;
	logic signed [DATA_W-1:0] query_q;

	logic                     req_take;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic [LW-1:0]            load_next;
	logic [LW-1:0]            scan_n;
	logic                     rd_en;
	logic [AW-1:0]            rd_addr;

	// stage 1: memory read data and tags
	logic signed [DATA_W-1:0] rd_data_s1;
	logic                     vld_s1;
	logic [AW-1:0]            idx_s1;
	logic                     use_s1;
	logic                     first_s1;
	logic signed [DATA_W-1:0] ent_s1;
	logic signed [DIFF_W-1:0] d_up_s1;
	logic signed [DIFF_W-1:0] d_dn_s1;

	// stage 2: absolute difference
	logic                     vld_s2;
	logic [DIFF_W-1:0]        abs_s2;
	logic signed [DATA_W-1:0] val_s2;
	logic [AW-1:0]            idx_s2;
	logic                     use_s2;
	logic                     first_s2;
	logic                     better_s2;

	// running best
	logic [BEST_W-1:0]        best_q;
	logic [BEST_W-1:0]        best_ref;
	logic [AW-1:0]            best_pos_q;
	logic signed [DATA_W-1:0] best_val_q;

	// output register
	logic                     out_valid_q;
	rsp_t                     out_q;
	logic                     scan_done;
	logic [AW+POS_W-1:0]      pos_wide;

	assign req.ready = (state_q == ST_IDLE);
	assign req_take  = req.valid && req.ready;

	// load path
	assign wr_en     = req_take && (req.payload.func == FUNC_LOAD) && (load_pos_q < DEPTH_L);
	assign wr_addr   = load_pos_q[AW-1:0];
	assign load_next = wr_en ? load_pos_q + LW'(1) : load_pos_q;

	// scan read issue
	assign scan_n  = (list_len_q == '0) ? LW'(1) : list_len_q;
	assign rd_en   = (state_q == ST_SCAN) && (scan_cnt_q < scan_n);
	assign rd_addr = scan_cnt_q[AW-1:0];

	// memory ports
	always_ff @(posedge clk) begin
		if (wr_en)
			value_mem[wr_addr] <= req.payload.value;
		if (rd_en)
			rd_data_s1 <= value_mem[rd_addr];
	end

	// entry zero reads as zero until it is written
	assign ent_s1  = (idx_s1 == '0 && !e0_written_q) ? '0 : rd_data_s1;
	assign d_up_s1 = DIFF_W'(ent_s1) - DIFF_W'(query_q);
	assign d_dn_s1 = DIFF_W'(query_q) - DIFF_W'(ent_s1);

	// first entry of a scan compares against the start value
	assign best_ref  = first_s2 ? START_BEST : best_q;
	assign better_s2 = use_s2 && (abs_s2 < DIFF_W'(best_ref));

	assign scan_done = (state_q == ST_SCAN) && (scan_cnt_q == scan_n) && !vld_s1 && !vld_s2
		&& (!out_valid_q || rsp.ready);

	// pipeline payload registers
	always_ff @(posedge clk) begin
		idx_s1   <= rd_addr;
		use_s1   <= scan_cnt_q < list_len_q;
		first_s1 <= scan_cnt_q == '0;
		abs_s2   <= d_up_s1[DIFF_W-1] ? d_dn_s1 : d_up_s1;
		val_s2   <= ent_s1;
		idx_s2   <= idx_s1;
		use_s2   <= use_s1;
		first_s2 <= first_s1;
		if (req_take)
			query_q <= req.payload.value;
	end

	// running best update, entry zero is the fallback
	always_ff @(posedge clk) begin
		if (vld_s2) begin
			if (first_s2) begin
				best_q     <= better_s2 ? abs_s2[BEST_W-1:0] : START_BEST;
				best_pos_q <= '0;
				best_val_q <= val_s2;
			end else if (better_s2) begin
				best_q     <= abs_s2[BEST_W-1:0];
				best_pos_q <= idx_s2;
				best_val_q <= val_s2;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			list_len_q   <= '0;
			load_pos_q   <= '0;
			e0_written_q <= 1'b0;
			scan_cnt_q   <= '0;
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			vld_s2 <= vld_s1;
			if (wr_en && wr_addr == '0)
				e0_written_q <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						if (req.payload.func == FUNC_LOAD) begin
							if (req.payload.load_last) begin
								list_len_q <= load_next;
								load_pos_q <= '0;
							end else begin
								load_pos_q <= load_next;
							end
						end else begin
							scan_cnt_q <= '0;
							state_q    <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_en)
						scan_cnt_q <= scan_cnt_q + LW'(1);
					if (scan_done)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result transaction register
	assign pos_wide = (AW + POS_W)'(best_pos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (scan_done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_done) begin
			out_q.closest_position <= pos_wide[POS_W-1:0];
			out_q.closest_value    <= best_val_q;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

endmodule

### design/nvs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvs_checker
// Port-level checks of the nearest value search transaction ordering.
// ----------------------------------------------------------------------------
module nvs_checker
	import nvs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic req_func,
	input logic rsp_valid,
	input logic rsp_ready
);

	// a stalled result stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result transaction dropped while stalled");

	// a query blocks further requests while it scans
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_func == FUNC_QUERY |=> !req_ready)
		else $error("request taken during a scan");

	// a load keeps the request channel ready in the following cycle
	a_load_one: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_func == FUNC_LOAD |=> req_ready)
		else $error("load did not complete in one cycle");

	// a new result only comes out of a scan
	a_rsp_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result without a scan");

endmodule

bind nearest_value_search nvs_checker u_nvs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_func  (req.payload.func),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_value_search testbench
// Loads tables of signed values and queries them for the nearest entry. A
// scoreboard keeps its own copy of the table, works out the expected
// position and value for each accepted query and checks every result in
// order. Requests come in random bursts, the result side stalls on its own
// pattern and once holds off long enough to back up the request channel.
// ----------------------------------------------------------------------------
module testbench;
	import nvs_pkg::*;

	localparam int LIST_DEPTH  = 256;
	localparam int ITEM_TARGET = 1050;
	localparam int CYCLE_LIMIT = 1_200_000;
	localparam int HOLD_START  = 2500;
	localparam int HOLD_CYCLES = 1500;
	localparam int DRAIN_WAIT  = 300;

	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

	logic clk;
	logic arst_n;

	nvs_stream_if #(.payload_t(req_t)) req_if ();
	nvs_stream_if #(.payload_t(rsp_t)) rsp_if ();

	nearest_value_search #(
		.LIST_DEPTH(LIST_DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	// shadow table and queue of expected nearest-entry results
	class nearest_scoreboard;
		logic signed [DATA_W-1:0] shadow_table [LIST_DEPTH];
		logic [8:0]               list_len;
		logic [8:0]               load_pos;
		rsp_t                     nearest_q [$];
		int unsigned              error_count;

		function new();
			foreach (shadow_table[i])
				shadow_table[i] = '0;
			list_len    = '0;
			load_pos    = '0;
			error_count = 0;
		endfunction

		// linear scan, first entry strictly closer than the running best wins
		function rsp_t find_nearest(input logic signed [DATA_W-1:0] query);
			longint best;
			longint diff;
			int     pos;
			rsp_t   res;
			best = longint'(START_BEST);
			pos  = 0;
			for (int i = 0; i < list_len; i++) begin
				diff = longint'(shadow_table[i]) - longint'(query);
				if (diff < 0)
					diff = -diff;
				if (diff < best) begin
					best = diff;
					pos  = i;
				end
			end
			res.closest_position = pos[POS_W-1:0];
			res.closest_value    = shadow_table[pos];
			return res;
		endfunction

		// accepted request transaction
		function void note_request(input req_t item);
			if (item.func == FUNC_LOAD) begin
				if (load_pos < LIST_DEPTH) begin
					shadow_table[load_pos] = item.value;
					load_pos++;
				end
				if (item.load_last) begin
					list_len = load_pos;
					load_pos = '0;
				end
			end else begin
				nearest_q.push_back(find_nearest(item.value));
			end
		endfunction

		// accepted result transaction
		function void check_response(input rsp_t got);
			rsp_t want;
			if (nearest_q.size() == 0) begin
				$display("%0t: unexpected result, position %0d value %0d", $time,
					got.closest_position, got.closest_value);
				error_count++;
				return;
			end
			want = nearest_q.pop_front();
			if (got.closest_position !== want.closest_position) begin
				$display("%0t: closest_position expected %0d actual %0d", $time,
					want.closest_position, got.closest_position);
				error_count++;
			end
			if (got.closest_value !== want.closest_value) begin
				$display("%0t: closest_value expected %0d actual %0d", $time,
					want.closest_value, got.closest_value);
				error_count++;
			end
		endfunction

		function int pending();
			return nearest_q.size();
		endfunction
	endclass

	nearest_scoreboard        sb;
	int                       items_sent;
	int                       burst_left;
	int                       long_lists;
	longint                   cycle_count;
	logic signed [DATA_W-1:0] recent_vals [$];

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watch both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_if.valid && req_if.ready)
				sb.note_request(req_if.payload);
			if (rsp_if.valid && rsp_if.ready)
				sb.check_response(rsp_if.payload);
		end
	end

	// one request transaction, preceded by a random gap between bursts
	task automatic send_request(input logic func, input logic signed [DATA_W-1:0] value,
			input logic last);
		req_t item;
		int   gap;
		item.func      = func;
		item.value     = value;
		item.load_last = last;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				req_if.valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		req_if.valid   <= 1'b1;
		req_if.payload <= item;
		do @(posedge clk); while (!req_if.ready);
		items_sent++;
	endtask

	function automatic logic signed [DATA_W-1:0] pick_entry_value();
		case ($urandom_range(0, 5))
			0: return ($urandom_range(0, 1) == 0) ? VAL_MAX : VAL_MIN;
			1: return int'($urandom_range(0, 8)) - 4;
			2: return ($urandom_range(0, 1) == 0) ? 1000000000 + int'($urandom_range(0, 6)) - 3
				: -1000000000 + int'($urandom_range(0, 6)) - 3;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_query_value();
		int sel;
		sel = $urandom_range(0, 5);
		if (sel == 1 && recent_vals.size() != 0)
			return recent_vals[$urandom_range(0, recent_vals.size() - 1)]
				+ (int'($urandom_range(0, 6)) - 3);
		case (sel)
			0: return ($urandom_range(0, 1) == 0) ? VAL_MAX : VAL_MIN;
			2: return int'($urandom_range(0, 8)) - 4;
			5: return ($urandom_range(0, 1) == 0) ? 0 : 1000000000;
			default: return $urandom();
		endcase
	endfunction

	// sequence of loads, optionally closed by a last-marked entry
	task automatic load_list(input int count, input bit close);
		logic signed [DATA_W-1:0] v;
		for (int k = 0; k < count; k++) begin
			v = pick_entry_value();
			recent_vals.push_back(v);
			if (recent_vals.size() > 16)
				void'(recent_vals.pop_front());
			send_request(FUNC_LOAD, v, close && (k == count - 1));
		end
	endtask

	task automatic run_queries(input int count);
		repeat (count)
			send_request(FUNC_QUERY, pick_query_value(), 1'($urandom_range(0, 1)));
	endtask

	// result side: changing stall pattern plus one long hold-off
	initial begin
		int rx_cycle;
		int mode;
		int mode_left;
		rx_cycle     = 0;
		mode         = 0;
		mode_left    = 0;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (rx_cycle == HOLD_START) begin
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_cycle += HOLD_CYCLES;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					0: rsp_if.ready <= 1'b1;
					1: rsp_if.ready <= 1'($urandom_range(0, 1));
					default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// cycle limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// stimulus
	initial begin
		req_if.valid   = 1'b0;
		req_if.payload = '0;
		arst_n         = 1'b0;
		items_sent     = 0;
		burst_left     = 0;
		long_lists     = 0;
		sb             = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty list, load_last ignored on a query
		send_request(FUNC_QUERY, 32'sd123, 1'b0);
		send_request(FUNC_QUERY, VAL_MIN, 1'b1);
		// extremes in the table, tie goes to the first entry
		send_request(FUNC_LOAD, VAL_MAX, 1'b0);
		send_request(FUNC_LOAD, VAL_MIN, 1'b0);
		send_request(FUNC_LOAD, 32'sd0, 1'b0);
		send_request(FUNC_LOAD, 32'sd7, 1'b0);
		send_request(FUNC_LOAD, 32'sd3, 1'b1);
		send_request(FUNC_QUERY, 32'sd5, 1'b0);
		send_request(FUNC_QUERY, VAL_MAX, 1'b0);
		send_request(FUNC_QUERY, VAL_MIN, 1'b0);
		send_request(FUNC_QUERY, -32'sd1, 1'b0);
		// query during an unfinished load sees the overwritten entries
		send_request(FUNC_LOAD, VAL_MIN, 1'b0);
		send_request(FUNC_LOAD, VAL_MAX, 1'b0);
		send_request(FUNC_QUERY, VAL_MIN, 1'b0);
		send_request(FUNC_LOAD, 32'sd0, 1'b1);
		// difference exactly at the start best is not taken, no entry qualifies
		send_request(FUNC_QUERY, 32'sd1000000000, 1'b0);
		send_request(FUNC_QUERY, 32'sd999999999, 1'b0);
		// last-marked load at position zero gives a one-entry list
		send_request(FUNC_LOAD, 32'sd0, 1'b1);
		send_request(FUNC_QUERY, VAL_MIN, 1'b0);

		// full table with loads past the depth dropped
		load_list(260, 1'b1);
		long_lists++;
		run_queries($urandom_range(2, 4));

		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				7: begin
					// unfinished load, queried midway
					load_list($urandom_range(1, 6), 1'b0);
					run_queries($urandom_range(1, 3));
				end
				8: send_request(FUNC_QUERY, $urandom(), 1'($urandom_range(0, 1)));
				9: send_request(FUNC_LOAD, pick_entry_value(), 1'b1);
				default: begin
					recent_vals.delete();
					if (long_lists < 2 && $urandom_range(0, 39) == 0) begin
						load_list($urandom_range(250, 262), 1'b1);
						long_lists++;
					end else begin
						load_list($urandom_range(1, 12), 1'b1);
					end
					run_queries($urandom_range(1, 6));
				end
			endcase
		end
		@(negedge clk);
		req_if.valid <= 1'b0;

		// drain outstanding results, then watch for strays
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
